// File: rtl/core/qedm_pkg.sv
package qedm_pkg;

  localparam int MODE_W      = 4;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int FUNC_W      = 3;
  localparam int CFG_ADDR_W  = 4;
  localparam int MAX_MODES   = 8;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_VERTEX    = 3'd0,
    FUNC_EDGE_INT  = 3'd1,
    FUNC_EDGE_FULL = 3'd2,
    FUNC_BOUNDARY  = 3'd3,
    FUNC_INTERIOR  = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    REG_MODES_FIRST  = 2'd0,
    REG_MODES_SECOND = 2'd1,
    REG_NODAL_FIRST  = 2'd2,
    REG_NODAL_SECOND = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    KIND_SINGLE,
    KIND_EDGE,
    KIND_SCAN,
    KIND_EMPTY,
    KIND_ERROR
  } kind_e;

  // clamped element geometry
  typedef struct packed {
    logic [MODE_W-1:0] n0;
    logic [MODE_W-1:0] n1;
    logic [MODE_W-1:0] h0;
    logic [MODE_W-1:0] h1;
    logic              nd0;
    logic              nd1;
  } geo_t;

  // one classified request
  typedef struct packed {
    kind_e             kind;
    logic [IDX_W-1:0]  base;
    logic [MODE_W-1:0] len;
    logic [MODE_W-1:0] t_start;
    logic              t_desc;
    logic              modal_full;
    logic              swap;
    logic              col;
    logic              bnd_query;
    logic [CNT_W-1:0]  total;
  } desc_t;

  function automatic logic [MODE_W-1:0] clamp_modes(logic [MODE_W-1:0] m);
    logic [MODE_W-1:0] r;
    r = m;
    if (m < MODE_W'(2)) r = MODE_W'(2);
    else if (m > MODE_W'(MAX_MODES)) r = MODE_W'(MAX_MODES);
    return r;
  endfunction

endpackage

// File: rtl/core/qedm_front.sv
module qedm_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [qedm_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [qedm_pkg::MODE_W-1:0]       cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // edge_id[1:0], backwards[2]
  input  logic [qedm_pkg::FUNC_W-1:0]       s_axis_tuser,  // func[2:0]
  input  logic                              full_i,
  output logic                              push_o,
  output qedm_pkg::desc_t                   desc_o,
  output qedm_pkg::geo_t                    geo_o
);
  import qedm_pkg::*;

  logic [MODE_W-1:0] modes_first_q, modes_second_q;
  logic              nodal_first_q, nodal_second_q;

  logic [MODE_W-1:0]   n0, n1, h0, h1, fixed, n_e;
  logic                nd0, nd1, nd_e, rev;
  logic [1:0]          edge_id;
  logic                backwards;
  logic [2*MODE_W-1:0] h1_n0, fixed_n0, area, inner;
  desc_t               d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modes_first_q  <= MODE_W'(2);
      modes_second_q <= MODE_W'(2);
      nodal_first_q  <= 1'b0;
      nodal_second_q <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_addr_i == CFG_ADDR_W'(REG_MODES_FIRST))  modes_first_q  <= cfg_data_i;
      if (cfg_addr_i == CFG_ADDR_W'(REG_MODES_SECOND)) modes_second_q <= cfg_data_i;
      if (cfg_addr_i == CFG_ADDR_W'(REG_NODAL_FIRST))  nodal_first_q  <= cfg_data_i[0];
      if (cfg_addr_i == CFG_ADDR_W'(REG_NODAL_SECOND)) nodal_second_q <= cfg_data_i[0];
    end
  end

  assign n0  = clamp_modes(modes_first_q);
  assign n1  = clamp_modes(modes_second_q);
  assign nd0 = nodal_first_q;
  assign nd1 = nodal_second_q;
  // far vertex: last node for Lagrange, mode 1 for modal
  assign h0  = nd0 ? n0 - MODE_W'(1) : MODE_W'(1);
  assign h1  = nd1 ? n1 - MODE_W'(1) : MODE_W'(1);

  assign geo_o = '{n0: n0, n1: n1, h0: h0, h1: h1, nd0: nd0, nd1: nd1};

  assign edge_id   = s_axis_tdata[1:0];
  assign backwards = s_axis_tdata[2];

  always_comb begin
    case (edge_id)
      2'd1:    fixed = h0;
      2'd2:    fixed = h1;
      default: fixed = '0;
    endcase
  end

  assign h1_n0    = {{MODE_W{1'b0}}, h1} * {{MODE_W{1'b0}}, n0};
  assign fixed_n0 = {{MODE_W{1'b0}}, fixed} * {{MODE_W{1'b0}}, n0};
  assign area     = {{MODE_W{1'b0}}, n0} * {{MODE_W{1'b0}}, n1};
  assign inner    = {{MODE_W{1'b0}}, n0 - MODE_W'(2)} * {{MODE_W{1'b0}}, n1 - MODE_W'(2)};

  // odd edges run along the second direction; nodal edges 2 and 3 descend unless backwards flips it
  assign n_e  = edge_id[0] ? n1 : n0;
  assign nd_e = edge_id[0] ? nd1 : nd0;
  assign rev  = edge_id[1] ^ backwards;

  always_comb begin
    d      = '0;
    d.kind = KIND_ERROR;
    case (func_e'(s_axis_tuser))
      FUNC_VERTEX: begin
        d.kind = KIND_SINGLE;
        case (edge_id)
          2'd0:    d.base = '0;
          2'd1:    d.base = IDX_W'(h0);
          2'd2:    d.base = h1_n0[IDX_W-1:0] + IDX_W'(h0);
          default: d.base = h1_n0[IDX_W-1:0];
        endcase
      end
      FUNC_EDGE_INT, FUNC_EDGE_FULL: begin
        d.kind = KIND_EDGE;
        d.col  = edge_id[0];
        d.base = edge_id[0] ? IDX_W'(fixed) : fixed_n0[IDX_W-1:0];
        if (s_axis_tuser == FUNC_EDGE_FULL) begin
          d.len = n_e;
          if (nd_e) begin
            d.t_start = rev ? n_e - MODE_W'(1) : '0;
            d.t_desc  = rev;
          end else begin
            d.modal_full = 1'b1;
            d.swap       = rev;
          end
        end else begin
          d.len = n_e - MODE_W'(2);
          if (nd_e) begin
            d.t_start = rev ? n_e - MODE_W'(2) : MODE_W'(1);
            d.t_desc  = rev;
          end else begin
            d.t_start = MODE_W'(2);
          end
          if (d.len == '0) d.kind = KIND_EMPTY;
        end
      end
      FUNC_BOUNDARY, FUNC_INTERIOR: begin
        d.kind      = KIND_SCAN;
        d.bnd_query = (s_axis_tuser == FUNC_BOUNDARY);
        d.total     = d.bnd_query ? CNT_W'(area - inner) : CNT_W'(inner);
        if (d.total == '0) d.kind = KIND_EMPTY;
      end
      default: d.kind = KIND_ERROR;
    endcase
  end

  assign desc_o        = d;
  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

endmodule

// File: rtl/core/qedm_queue.sv
module qedm_queue #(
  parameter int DEPTH = qedm_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  qedm_pkg::desc_t desc_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output qedm_pkg::desc_t desc_o
);
  import qedm_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t           mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign desc_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= desc_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      if (do_push && !do_pop)      count_q <= count_q + CW'(1);
      else if (do_pop && !do_push) count_q <= count_q - CW'(1);
    end
  end

endmodule

// File: rtl/core/qedm_back.sv
module qedm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  qedm_pkg::geo_t                geo_i,
  input  logic                          q_valid_i,
  input  qedm_pkg::desc_t               q_desc_i,
  output logic                          pop_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // dof_index[5:0]
  output logic                          m_axis_tlast,  // last
  output logic [1:0]                    m_axis_tuser   // empty_res[0], error[1]
);
  import qedm_pkg::*;

  desc_t             cur_q;
  logic              busy_q;
  logic [MODE_W-1:0] k_q, i_q, j_q;
  logic [CNT_W-1:0]  cnt_q;

  logic              out_valid_q, out_last_q, out_empty_q, out_err_q;
  logic [IDX_W-1:0]  out_idx_q;

  logic                adv, step;
  logic [MODE_W-1:0]   t_edge;
  logic [2*MODE_W-1:0] t_prod, j_prod;
  logic [IDX_W-1:0]    edge_idx, scan_idx;
  logic                is_bnd, match;
  logic                emit, last, empty_f, err_f, done;
  logic [IDX_W-1:0]    idx;

  assign adv   = !out_valid_q || m_axis_tready;
  assign step  = busy_q && adv;
  assign pop_o = q_valid_i && !busy_q;

  // modal full edge: two vertex modes (possibly swapped), then interior ascending
  always_comb begin
    if (cur_q.modal_full) begin
      if (k_q == '0)                t_edge = {{(MODE_W-1){1'b0}}, cur_q.swap};
      else if (k_q == MODE_W'(1))   t_edge = {{(MODE_W-1){1'b0}}, !cur_q.swap};
      else                          t_edge = k_q;
    end else begin
      t_edge = cur_q.t_desc ? cur_q.t_start - k_q : cur_q.t_start + k_q;
    end
  end

  assign t_prod   = {{MODE_W{1'b0}}, t_edge} * {{MODE_W{1'b0}}, geo_i.n0};
  assign edge_idx = cur_q.base + (cur_q.col ? t_prod[IDX_W-1:0] : IDX_W'(t_edge));

  assign j_prod   = {{MODE_W{1'b0}}, j_q} * {{MODE_W{1'b0}}, geo_i.n0};
  assign scan_idx = j_prod[IDX_W-1:0] + IDX_W'(i_q);

  always_comb begin
    is_bnd = (j_q == '0) || (j_q == geo_i.h1) || (i_q == '0) || (i_q == geo_i.h0);
    if (!geo_i.nd1 && j_q <= MODE_W'(1)) is_bnd = 1'b1;
    if (!geo_i.nd0 && i_q <= MODE_W'(1)) is_bnd = 1'b1;
  end
  assign match = (is_bnd == cur_q.bnd_query);

  always_comb begin
    emit    = 1'b0;
    last    = 1'b0;
    empty_f = 1'b0;
    err_f   = 1'b0;
    done    = 1'b0;
    idx     = '0;
    case (cur_q.kind)
      KIND_SINGLE: begin
        emit = 1'b1;
        last = 1'b1;
        idx  = cur_q.base;
      end
      KIND_EMPTY: begin
        emit    = 1'b1;
        last    = 1'b1;
        empty_f = 1'b1;
      end
      KIND_ERROR: begin
        emit  = 1'b1;
        last  = 1'b1;
        err_f = 1'b1;
      end
      KIND_EDGE: begin
        emit = 1'b1;
        idx  = edge_idx;
        last = (k_q == cur_q.len - MODE_W'(1));
      end
      KIND_SCAN: begin
        emit = match;
        idx  = scan_idx;
        last = match && (cnt_q == cur_q.total - CNT_W'(1));
      end
      default: last = 1'b1;
    endcase
    done = last;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= q_desc_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
      i_q    <= '0;
      j_q    <= '0;
      cnt_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      k_q    <= '0;
      i_q    <= '0;
      j_q    <= '0;
      cnt_q  <= '0;
    end else if (step) begin
      k_q <= k_q + MODE_W'(1);
      if (i_q == geo_i.n0 - MODE_W'(1)) begin
        i_q <= '0;
        j_q <= j_q + MODE_W'(1);
      end else begin
        i_q <= i_q + MODE_W'(1);
      end
      if (emit) cnt_q <= cnt_q + CNT_W'(1);
      if (done) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= step && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_idx_q   <= idx;
      out_last_q  <= last;
      out_empty_q <= empty_f;
      out_err_q   <= err_f;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(8-IDX_W){1'b0}}, out_idx_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = {out_err_q, out_empty_q};

  a_flag_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_err_q && out_empty_q))
    else $error("empty and error flagged together");

  a_flag_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_err_q || out_empty_q) |-> out_last_q)
    else $error("flagged result not last of run");

  a_scan_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cur_q.kind == KIND_SCAN |-> cnt_q < cur_q.total)
    else $error("scan emitted more than its count");

  a_edge_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cur_q.kind == KIND_EDGE |-> k_q < cur_q.len)
    else $error("edge counter past run length");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && step && done |=> !busy_q)
    else $error("run did not finish after last index");

endmodule

// File: rtl/core/quad_element_dof_index_map.sv
// Path: accepted requests wait in the queue, are popped into the back end's current
// request register and leave via the output register; interior scans first seek an interior cell.
// Throughput: one index per cycle for vertex and edge runs (run length, at most 8) unless the
// output stalls; boundary and interior runs scan the n0*n1 grid (up to 64 positions). A new request
// is popped only after the last run ends. Reset: asynchronous active low; mode counts reset to 2,
// both directions modal, queue and output register empty.
module quad_element_dof_index_map #(
  parameter int QUEUE_DEPTH = qedm_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [qedm_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [qedm_pkg::MODE_W-1:0]     cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // edge_id[1:0], backwards[2]
  input  logic [qedm_pkg::FUNC_W-1:0]     s_axis_tuser,  // func[2:0]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // dof_index[5:0]
  output logic                            m_axis_tlast,  // last
  output logic [1:0]                      m_axis_tuser   // empty_res[0], error[1]
);
  import qedm_pkg::*;

  desc_t push_desc, q_desc;
  geo_t  geo;
  logic  push, full, q_valid, pop;

  qedm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (full),
    .push_o        (push),
    .desc_o        (push_desc),
    .geo_o         (geo)
  );

  qedm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (push_desc),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .desc_o  (q_desc)
  );

  qedm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .geo_i         (geo),
    .q_valid_i     (q_valid),
    .q_desc_i      (q_desc),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
